[rtl/c2p_pkg.sv]
// Shared types and constants for the Cartesian-to-polar converter.
// Holds the pipeline control struct, the CORDIC arctangent table and angle constants.
// No dependencies.
package c2p_pkg;

   // control bits that travel with each beat through the pipeline
   typedef struct packed {
      logic valid;
      logic origin;
   } c2p_ctl_type;

   // CORDIC fixed point
   localparam int FRAC_BITS = 24;
   localparam int TABLE_LEN = 24;
   localparam int ANG_W     = 32;

   // angle accumulator is in units of 2^-22 degree
   localparam logic signed [ANG_W-1:0] Z_180 = 32'sd754974720;
   localparam logic signed [ANG_W-1:0] Z_360 = 32'sd1509949440;

   // output rounding to 1/128 degree
   localparam int            ANG_SHIFT   = 15;
   localparam logic [ANG_W:0] ROUND_HALF = 33'd16384;
   localparam logic [15:0]    FULL_CIRCLE = 16'd46080;

   // round(atan(2^-i) * 180/pi * 2^22)
   localparam logic signed [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
      32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
      32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
      32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
      32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
      32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
      32'sd229,       32'sd115,       32'sd57,       32'sd29
   };

endpackage

[rtl/c2p_front.sv]
// Front end of the converter: squares, half-plane fold and CORDIC seeding.
// Two register stages feeding the first cell of the chain.
// Depends on c2p_pkg.
module c2p_front #(
   parameter int IN_W = 16,
   parameter int XW   = 43,
   parameter int N_W  = 33
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic signed [IN_W-1:0]             x_in,
   input  logic signed [IN_W-1:0]             y_in,
   output c2p_pkg::c2p_ctl_type               ctl_out,
   output logic [N_W-1:0]                     n_out,
   output logic signed [XW-1:0]               cx_out,
   output logic signed [XW-1:0]               cy_out,
   output logic signed [c2p_pkg::ANG_W-1:0]   z_out
);
   import c2p_pkg::*;

   localparam int SQ_W = 2 * IN_W;
   localparam int PAD  = XW - IN_W - 1 - FRAC_BITS;

   logic [IN_W-1:0]       ax, ay;
   logic [SQ_W-1:0]       ax_w, ay_w;
   logic signed [IN_W:0]  xe, ye;
   logic                  neg;

   c2p_ctl_type           ctl_a_ff, ctl_a_in;
   logic [SQ_W-1:0]       sqx_a_ff, sqx_a_in, sqy_a_ff, sqy_a_in;
   logic signed [IN_W:0]  cx_a_ff, cx_a_in, cy_a_ff, cy_a_in;
   logic                  neg_a_ff;

   c2p_ctl_type           ctl_b_ff;
   logic [N_W-1:0]        n_b_ff, n_b_in;
   logic signed [XW-1:0]  cx_b_ff, cx_b_in, cy_b_ff, cy_b_in;
   logic signed [ANG_W-1:0] z_b_ff, z_b_in;

   // stage A: absolute values squared, left half-plane turned by 180 degrees
   always_comb begin
      ax       = x_in[IN_W-1] ? IN_W'(-x_in) : IN_W'(x_in);
      ay       = y_in[IN_W-1] ? IN_W'(-y_in) : IN_W'(y_in);
      ax_w     = {{IN_W{1'b0}}, ax};
      ay_w     = {{IN_W{1'b0}}, ay};
      sqx_a_in = ax_w * ax_w;
      sqy_a_in = ay_w * ay_w;
      xe       = {x_in[IN_W-1], x_in};
      ye       = {y_in[IN_W-1], y_in};
      neg      = x_in[IN_W-1];
      cx_a_in  = neg ? -xe : xe;
      cy_a_in  = neg ? -ye : ye;
      ctl_a_in.valid  = accept;
      ctl_a_in.origin = (x_in == '0) && (y_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
      end else begin
         ctl_a_ff <= ctl_a_in;
      end
      sqx_a_ff <= sqx_a_in;
      sqy_a_ff <= sqy_a_in;
      cx_a_ff  <= cx_a_in;
      cy_a_ff  <= cy_a_in;
      neg_a_ff <= neg;
   end

   // stage B: sum of squares, scale coordinates, seed the angle
   always_comb begin
      n_b_in  = {1'b0, sqx_a_ff} + {1'b0, sqy_a_ff};
      cx_b_in = {{PAD{cx_a_ff[IN_W]}}, cx_a_ff, {FRAC_BITS{1'b0}}};
      cy_b_in = {{PAD{cy_a_ff[IN_W]}}, cy_a_ff, {FRAC_BITS{1'b0}}};
      z_b_in  = neg_a_ff ? Z_180 : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_b_ff <= '0;
      end else begin
         ctl_b_ff <= ctl_a_ff;
      end
      n_b_ff  <= n_b_in;
      cx_b_ff <= cx_b_in;
      cy_b_ff <= cy_b_in;
      z_b_ff  <= z_b_in;
   end

   assign ctl_out = ctl_b_ff;
   assign n_out   = n_b_ff;
   assign cx_out  = cx_b_ff;
   assign cy_out  = cy_b_ff;
   assign z_out   = z_b_ff;

endmodule

[rtl/c2p_cell.sv]
// One cell of the chain: one CORDIC micro-rotation and one square-root digit.
// Each step is enabled by its position; a disabled step passes its data on.
// Depends on c2p_pkg.
module c2p_cell #(
   parameter int STEP = 0,
   parameter int NI   = 16,
   parameter int RB   = 17,
   parameter int N_W  = 33,
   parameter int XW   = 43
) (
   input  logic                               clock,
   input  logic                               reset,
   input  c2p_pkg::c2p_ctl_type               ctl_in,
   input  logic [N_W-1:0]                     n_in,
   input  logic [N_W:0]                       r_in,
   input  logic signed [XW-1:0]               cx_in,
   input  logic signed [XW-1:0]               cy_in,
   input  logic signed [c2p_pkg::ANG_W-1:0]   z_in,
   output c2p_pkg::c2p_ctl_type               ctl_out,
   output logic [N_W-1:0]                     n_out,
   output logic [N_W:0]                       r_out,
   output logic signed [XW-1:0]               cx_out,
   output logic signed [XW-1:0]               cy_out,
   output logic signed [c2p_pkg::ANG_W-1:0]   z_out
);
   import c2p_pkg::*;

   localparam int R_W = N_W + 1;

   c2p_ctl_type             ctl_ff;
   logic [N_W-1:0]          n_ff, n_in_next;
   logic [R_W-1:0]          r_ff, r_in_next;
   logic signed [XW-1:0]    cx_ff, cx_in_next, cy_ff, cy_in_next;
   logic signed [ANG_W-1:0] z_ff, z_in_next;

   // square-root digit: restoring step against the current power of four
   if (STEP < RB) begin : g_sqrt
      localparam int             B_SHIFT = 2 * (RB - 1 - STEP);
      localparam logic [R_W-1:0] B_VAL   = {{(R_W-1){1'b0}}, 1'b1} << B_SHIFT;
      logic [R_W-1:0] trial;
      always_comb begin
         trial = r_in + B_VAL;
         if ({1'b0, n_in} >= trial) begin
            n_in_next = n_in - trial[N_W-1:0];
            r_in_next = (r_in >> 1) + B_VAL;
         end else begin
            n_in_next = n_in;
            r_in_next = r_in >> 1;
         end
      end
   end else begin : g_sqrt_pass
      assign n_in_next = n_in;
      assign r_in_next = r_in;
   end

   // CORDIC micro-rotation: drive y toward zero, y of zero turns clockwise
   if (STEP < NI) begin : g_rot
      localparam logic signed [ANG_W-1:0] ATAN_STEP = ATAN_TAB[STEP];
      logic signed [XW-1:0] dx, dy;
      always_comb begin
         dx = cy_in >>> STEP;
         dy = cx_in >>> STEP;
         if (!cy_in[XW-1]) begin
            cx_in_next = cx_in + dx;
            cy_in_next = cy_in - dy;
            z_in_next  = z_in + ATAN_STEP;
         end else begin
            cx_in_next = cx_in - dx;
            cy_in_next = cy_in + dy;
            z_in_next  = z_in - ATAN_STEP;
         end
      end
   end else begin : g_rot_pass
      assign cx_in_next = cx_in;
      assign cy_in_next = cy_in;
      assign z_in_next  = z_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      n_ff  <= n_in_next;
      r_ff  <= r_in_next;
      cx_ff <= cx_in_next;
      cy_ff <= cy_in_next;
      z_ff  <= z_in_next;
   end

   assign ctl_out = ctl_ff;
   assign n_out   = n_ff;
   assign r_out   = r_ff;
   assign cx_out  = cx_ff;
   assign cy_out  = cy_ff;
   assign z_out   = z_ff;

endmodule

[rtl/c2p_back.sv]
// Back end of the converter: rounds the root and the angle, registers the result beat.
// Angle is wrapped into [0, 360) degrees and rounded to 1/128 degree.
// Depends on c2p_pkg.
module c2p_back #(
   parameter int N_W = 33
) (
   input  logic                               clock,
   input  logic                               reset,
   input  c2p_pkg::c2p_ctl_type               ctl_in,
   input  logic [N_W-1:0]                     n_in,
   input  logic [N_W:0]                       r_in,
   input  logic signed [c2p_pkg::ANG_W-1:0]   z_in,
   output logic                               strobe,
   output logic [15:0]                        magnitude,
   output logic [15:0]                        angle_deg
);
   import c2p_pkg::*;

   localparam int R_W = N_W + 1;

   logic [R_W-1:0]   root_rnd;
   logic [ANG_W-1:0] z_pos;
   logic [ANG_W:0]   z_half;
   logic [15:0]      ang_raw;

   logic             strobe_ff;
   logic [15:0]      mag_ff, mag_in, ang_ff, ang_in;

   // round the root up when the remainder exceeds it
   always_comb begin
      root_rnd = ({1'b0, n_in} > r_in) ? r_in + 1'b1 : r_in;
      mag_in   = root_rnd[15:0];
   end

   // bring the angle into one turn, round, fold 360 degrees back to zero
   always_comb begin
      z_pos   = z_in[ANG_W-1] ? ANG_W'(z_in + Z_360) : ANG_W'(z_in);
      z_half  = {1'b0, z_pos} + ROUND_HALF;
      ang_raw = z_half[ANG_SHIFT +: 16];
      if (ctl_in.origin) begin
         ang_in = '0;
      end else if (ang_raw >= FULL_CIRCLE) begin
         ang_in = ang_raw - FULL_CIRCLE;
      end else begin
         ang_in = ang_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl_in.valid;
      end
      mag_ff <= mag_in;
      ang_ff <= ang_in;
   end

   assign strobe    = strobe_ff;
   assign magnitude = mag_ff;
   assign angle_deg = ang_ff;

endmodule

[rtl/cartesian_to_polar.sv]
// Path from the accepting edge to the result beat: front stages A and B, a chain of NC cells,
//   NC = max(min(ITERATIONS,24), IN_W+1), then the back-end output register.
// Throughput: one point per clock; busy is high only while reset is asserted.
// The cell chain sets the length; each cell does at most one CORDIC rotation and one root digit.
// Reset (synchronous) clears every valid bit; points in flight are dropped.
// The receiver cannot stall: each result beat shows on rsp_strobe for exactly one cycle.
module cartesian_to_polar #(
   parameter int ITERATIONS = 16,
   parameter int DATA_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_x_coord,
   input  logic signed [15:0] req_y_coord,
   output logic               rsp_strobe,
   output logic [15:0]        rsp_magnitude,
   output logic [15:0]        rsp_angle_deg
);
   import c2p_pkg::*;

   localparam int IN_W    = (DATA_WIDTH > 16) ? 17 : DATA_WIDTH;
   localparam int XW      = IN_W + 3 + FRAC_BITS;
   localparam int N_W     = 2 * IN_W + 1;
   localparam int RB      = IN_W + 1;
   localparam int NI      = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;
   localparam int NC      = (NI > RB) ? NI : RB;
   localparam int LATENCY = NC + 3;

   logic                    accept;
   logic signed [IN_W-1:0]  x_ext, y_ext;

   c2p_ctl_type             ctl_w [NC+1];
   logic [N_W-1:0]          n_w   [NC+1];
   logic [N_W:0]            r_w   [NC+1];
   logic signed [XW-1:0]    cx_w  [NC+1];
   logic signed [XW-1:0]    cy_w  [NC+1];
   logic signed [ANG_W-1:0] z_w   [NC+1];

   assign busy   = reset;
   assign accept = start && !busy;

   // narrow widths take the low bits as a signed value, wide ones take the port as unsigned
   if (DATA_WIDTH > 16) begin : g_wide
      assign x_ext = {1'b0, req_x_coord};
      assign y_ext = {1'b0, req_y_coord};
   end else begin : g_narrow
      assign x_ext = req_x_coord[IN_W-1:0];
      assign y_ext = req_y_coord[IN_W-1:0];
   end

   c2p_front #(
      .IN_W (IN_W),
      .XW   (XW),
      .N_W  (N_W)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .x_in    (x_ext),
      .y_in    (y_ext),
      .ctl_out (ctl_w[0]),
      .n_out   (n_w[0]),
      .cx_out  (cx_w[0]),
      .cy_out  (cy_w[0]),
      .z_out   (z_w[0])
   );

   assign r_w[0] = '0;

   // chain of cells
   for (genvar k = 0; k < NC; k++) begin : g_cell
      c2p_cell #(
         .STEP (k),
         .NI   (NI),
         .RB   (RB),
         .N_W  (N_W),
         .XW   (XW)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl_in  (ctl_w[k]),
         .n_in    (n_w[k]),
         .r_in    (r_w[k]),
         .cx_in   (cx_w[k]),
         .cy_in   (cy_w[k]),
         .z_in    (z_w[k]),
         .ctl_out (ctl_w[k+1]),
         .n_out   (n_w[k+1]),
         .r_out   (r_w[k+1]),
         .cx_out  (cx_w[k+1]),
         .cy_out  (cy_w[k+1]),
         .z_out   (z_w[k+1])
      );
   end

   c2p_back #(
      .N_W (N_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (ctl_w[NC]),
      .n_in      (n_w[NC]),
      .r_in      (r_w[NC]),
      .z_in      (z_w[NC]),
      .strobe    (rsp_strobe),
      .magnitude (rsp_magnitude),
      .angle_deg (rsp_angle_deg)
   );

endmodule

[rtl/c2p_checker.sv]
// Port-level checker for the Cartesian-to-polar converter, bound to the top level.
// Checks fixed latency, beat count, angle range and the origin case.
// Depends on c2p_pkg and cartesian_to_polar.
module c2p_checker #(
   parameter int LATENCY = 20
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic signed [15:0] req_x_coord,
   input logic signed [15:0] req_y_coord,
   input logic               rsp_strobe,
   input logic [15:0]        rsp_magnitude,
   input logic [15:0]        rsp_angle_deg
);
   import c2p_pkg::*;

   // every accepted beat yields a result beat a fixed time later
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("result beat missing after accepted point");

   // no result beat without an accepted point
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##LATENCY !rsp_strobe)
      else $error("result beat without accepted point");

   // angle stays below one full turn
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_angle_deg < FULL_CIRCLE))
      else $error("angle out of range");

   // origin gives zero radius and zero angle
   a_origin: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_x_coord == 16'sd0 && req_y_coord == 16'sd0)
         |-> ##LATENCY (rsp_magnitude == 16'd0 && rsp_angle_deg == 16'd0))
      else $error("origin not mapped to zero");

endmodule

bind cartesian_to_polar c2p_checker #(
   .LATENCY (LATENCY)
) u_c2p_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_x_coord   (req_x_coord),
   .req_y_coord   (req_y_coord),
   .rsp_strobe    (rsp_strobe),
   .rsp_magnitude (rsp_magnitude),
   .rsp_angle_deg (rsp_angle_deg)
);

[test/tb.sv]
// Self-checking bench for cartesian_to_polar: drives points, predicts magnitude and angle,
// and checks every result beat in order. Depends on rtl/c2p_pkg.sv and
// rtl/cartesian_to_polar.sv; the prediction is written here and shares no code with the RTL.
module tb;

   localparam int ITERATIONS = 16;
   localparam int DATA_WIDTH = 16;
   localparam int N_RANDOM   = 2000;
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_WAIT = 40;

   typedef struct {
      logic [15:0] magnitude;
      logic [15:0] angle_deg;
   } polar_point_type;

   // Holds the predicted polar results in arrival order and checks the DUT against them
   class polar_scoreboard_type;
      polar_point_type expected_polar[$];
      int fails;
      int points;
      int left_half;
      int origins;
      int checked;

      // atan(2^-i) in units of 2^-22 degree
      function longint atan_step(int i);
         case (i)
            0:  return 188743680;
            1:  return 111421900;
            2:  return 58872272;
            3:  return 29884485;
            4:  return 15000234;
            5:  return 7507429;
            6:  return 3754631;
            7:  return 1877430;
            8:  return 938729;
            9:  return 469366;
            10: return 234683;
            11: return 117342;
            12: return 58671;
            13: return 29335;
            14: return 14668;
            15: return 7334;
            16: return 3667;
            17: return 1833;
            18: return 917;
            19: return 458;
            20: return 229;
            21: return 115;
            22: return 57;
            default: return 29;
         endcase
      endfunction

      // round(sqrt(x^2 + y^2)) by a bitwise integer root
      function logic [15:0] polar_magnitude(longint x, longint y);
         longint unsigned ax, ay, n, r, b;
         ax = (x < 0) ? longint'(-x) : longint'(x);
         ay = (y < 0) ? longint'(-y) : longint'(y);
         n  = ax * ax + ay * ay;
         r  = 0;
         b  = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         // n now holds the remainder x^2+y^2-r^2
         if (n > r) r = r + 1;
         return r[15:0];
      endfunction

      // four-quadrant angle by vectoring CORDIC, in 1/128 degree
      function logic [15:0] polar_angle(longint x, longint y);
         longint z, cx, cy, dx, dy;
         longint unsigned a;
         int steps;
         if (x == 0 && y == 0) return 16'd0;
         z = 0;
         // left half-plane: turn by 180 degrees first
         if (x < 0) begin
            x = -x;
            y = -y;
            z = 64'sd180 * 64'sd4194304;
         end
         cx = x * 64'sd16777216;
         cy = y * 64'sd16777216;
         steps = (ITERATIONS < 24) ? ITERATIONS : 24;
         for (int i = 0; i < steps; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            // y of zero counts as non-negative
            if (cy >= 0) begin
               cx = cx + dx;
               cy = cy - dy;
               z  = z + atan_step(i);
            end else begin
               cx = cx - dx;
               cy = cy + dy;
               z  = z - atan_step(i);
            end
         end
         if (z < 0) z = z + 64'sd360 * 64'sd4194304;
         a = (longint'(z) + 64'd16384) >> 15;
         // a full circle rounds back to zero
         if (a >= 64'd46080) a = a - 64'd46080;
         return a[15:0];
      endfunction

      function void note_point(logic signed [15:0] x, logic signed [15:0] y);
         polar_point_type p;
         longint lx, ly;
         lx = longint'(x);
         ly = longint'(y);
         p.magnitude = polar_magnitude(lx, ly);
         p.angle_deg = polar_angle(lx, ly);
         expected_polar.push_back(p);
         points++;
         if (lx < 0) left_half++;
         if (lx == 0 && ly == 0) origins++;
      endfunction

      function void check_result(logic [15:0] magnitude, logic [15:0] angle_deg);
         polar_point_type p;
         if (expected_polar.size() == 0) begin
            $display("%0t: unexpected result beat mag=%0d angle=%0d",
                     $time, magnitude, angle_deg);
            fails++;
            return;
         end
         p = expected_polar.pop_front();
         checked++;
         if (magnitude !== p.magnitude) begin
            $display("%0t: magnitude mismatch expected %0d actual %0d",
                     $time, p.magnitude, magnitude);
            fails++;
         end
         if (angle_deg !== p.angle_deg) begin
            $display("%0t: angle_deg mismatch expected %0d actual %0d",
                     $time, p.angle_deg, angle_deg);
            fails++;
         end
      endfunction

      function int pending();
         return expected_polar.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic signed [15:0] req_x_coord = '0;
   logic signed [15:0] req_y_coord = '0;
   logic               busy;
   logic               rsp_strobe;
   logic [15:0]        rsp_magnitude;
   logic [15:0]        rsp_angle_deg;

   polar_scoreboard_type sb = new();
   int idle_cycles = 0;
   bit burst_mode  = 1'b0;
   int drain_pauses = 0;

   cartesian_to_polar #(
      .ITERATIONS(ITERATIONS),
      .DATA_WIDTH(DATA_WIDTH)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_x_coord  (req_x_coord),
      .req_y_coord  (req_y_coord),
      .rsp_strobe   (rsp_strobe),
      .rsp_magnitude(rsp_magnitude),
      .rsp_angle_deg(rsp_angle_deg)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watch both channels at each edge; values read here are the pre-edge ones
   always @(posedge clock) begin
      if (rsp_strobe && !reset) sb.check_result(rsp_magnitude, rsp_angle_deg);
      if (start && !busy && !reset) sb.note_point(req_x_coord, req_y_coord);
   end

   // watchdog on stretches with no beat on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // present one point and hold it until taken, then idle a random gap (none in burst mode)
   task automatic send_point(logic signed [15:0] x, logic signed [15:0] y);
      int gap;
      start       <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      do @(posedge clock); while (busy);
      gap = burst_mode ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold the sender off until every predicted result has come back
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      drain_pauses++;
   endtask

   function automatic logic signed [15:0] edge_value();
      case ($urandom_range(0, 6))
         0: return -16'sd32768;
         1: return -16'sd32767;
         2: return -16'sd1;
         3: return 16'sd0;
         4: return 16'sd1;
         5: return 16'sd32766;
         default: return 16'sd32767;
      endcase
   endfunction

   // random point drawn from a mix of shapes
   task automatic send_random_point();
      logic signed [15:0] x, y;
      int pick;
      pick = $urandom_range(0, 9);
      x = 16'($urandom());
      y = 16'($urandom());
      case (pick)
         4: begin
            x = 16'($signed($urandom_range(0, 32)) - 16);
            y = 16'($signed($urandom_range(0, 32)) - 16);
         end
         5: begin
            if ($urandom_range(0, 1)) x = 0;
            else y = 0;
         end
         6: begin
            y = $urandom_range(0, 1) ? x : -x;
            y = y + 16'($signed($urandom_range(0, 4)) - 2);
         end
         7: begin
            x = edge_value();
            y = edge_value();
         end
         8: begin
            // on or just below the positive x axis, near the full-circle wrap
            x = 16'($urandom_range(1000, 32767));
            y = -16'($urandom_range(0, 40));
         end
         9: x[15] = 1'b1;
         default: ;
      endcase
      send_point(x, y);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: origin, axes, corners, left half-plane, wrap and zero-y rotation
      burst_mode = 1'b1;
      send_point(16'sd0, 16'sd0);
      send_point(16'sd32767, 16'sd0);
      send_point(-16'sd32768, 16'sd0);
      send_point(16'sd0, 16'sd32767);
      send_point(16'sd0, -16'sd32768);
      send_point(16'sd32767, 16'sd32767);
      send_point(-16'sd32768, -16'sd32768);
      send_point(16'sd32767, -16'sd32768);
      send_point(-16'sd32768, 16'sd32767);
      burst_mode = 1'b0;
      send_point(16'sd1, 16'sd0);
      send_point(-16'sd1, 16'sd0);
      send_point(16'sd0, 16'sd1);
      send_point(16'sd0, -16'sd1);
      send_point(16'sd32767, -16'sd1);
      send_point(16'sd20000, -16'sd1);
      send_point(16'sd1, 16'sd1);
      send_point(-16'sd5, -16'sd5);
      send_point(16'sd100, 16'sd100);
      send_point(16'sd1, -16'sd1);
      send_point(-16'sd1, 16'sd1);
      send_point(16'sd3, 16'sd4);
      send_point(-16'sd3, -16'sd4);
      send_point(-16'sd32768, -16'sd1);
      send_point(-16'sd32768, 16'sd1);
      drain_results();

      // random: each stretch of 100 points is a burst with no gaps or a gapped stretch, with rare full drains
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 199) == 0) drain_results();
         send_random_point();
      end
      start <= 1'b0;

      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Converted %0d points (%0d left half-plane, %0d origin), %0d results checked,",
               sb.points, sb.left_half, sb.origins, sb.checked);
      $display("with %0d full drains of the pipeline and %0d mismatches.",
               drain_pauses, sb.fails);
      if (sb.fails == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/c2p_pkg.sv
rtl/c2p_front.sv
rtl/c2p_cell.sv
rtl/c2p_back.sv
rtl/cartesian_to_polar.sv
rtl/c2p_checker.sv
test/tb.sv
